// File: design/idr_pkg.sv
package idr_pkg;

    // graph and stack sizes
    localparam int NUM_VERTICES = 1024;
    localparam int NUM_EDGES    = 4096;
    localparam int STACK_DEPTH  = 1024;

    localparam int VTX_W  = $clog2(NUM_VERTICES);       // vertex index
    localparam int VIN_W  = VTX_W + 1;                  // vertex field incl. sentinel
    localparam int EDG_W  = $clog2(NUM_EDGES);          // edge slot index
    localparam int SLOT_W = EDG_W + 1;                  // slot value incl. end marker
    localparam int STK_W  = $clog2(STACK_DEPTH);        // stack index
    localparam int SP_W   = STK_W + 1;                  // stack pointer
    localparam int LBL_W  = 10;                         // label field width

    // command codes
    localparam logic [1:0] CMD_LOAD_VTX  = 2'd0;
    localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
    localparam logic [1:0] CMD_QUERY     = 2'd2;

    // vertex record as held in the vertex memory
    typedef struct packed {
        logic [LBL_W-1:0] level;
        logic [LBL_W-1:0] rank_y;
        logic [LBL_W-1:0] rank_x;
        logic [LBL_W-1:0] int_hi;
        logic [LBL_W-1:0] int_lo;
    } t_vattr;

    // one input item unpacked
    typedef struct packed {
        logic [1:0]        cmd;
        logic [VIN_W-1:0]  vertex;
        logic [VTX_W-1:0]  target_vertex;
        logic [SLOT_W-1:0] first_edge;
        logic [EDG_W-1:0]  edge_slot;
        logic [VTX_W-1:0]  edge_target;
        t_vattr            attr;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_tgt;
        logic ld_tgt;
        logic start;
        logic ld_fe0;
        logic rd_fe1;
        logic ld_fe1;
        logic adv;
        logic push;
        logic pop;
        logic ld_top;
        logic set_res;
        logic res_flag;
        logic res_bad;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic range_ok;
        logic first;
        logic hit;
        logic prune;
        logic has_child;
        logic child_oob;
        logic stack_full;
        logic sp_last;
        logic out_busy;
    } t_status;

endpackage

// File: design/idr_ram.sv
module idr_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/idr_datapath.sv
module idr_datapath
    import idr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_item    i_item,
    input  t_cmd     i_cmd,
    input  logic     i_m_tready,
    output t_status  o_status,
    output logic     o_m_tvalid,
    output logic [1:0] o_result
);
    logic [VTX_W-1:0]  r_src, r_dst, r_node;
    logic [SLOT_W-1:0] r_slot, r_fe0, r_fe1;
    logic              r_fresh;
    logic [SP_W-1:0]   r_sp;
    t_vattr            r_t, r_n;
    logic              r_res_flag, r_res_bad, r_out_valid;
    logic [1:0]        r_out;

    logic [VIN_W-1:0]          fe_raddr, fe_waddr;
    logic [SLOT_W-1:0]         fe_rdata;
    logic                      fe_we;
    logic [VTX_W-1:0]          va_raddr;
    logic [$bits(t_vattr)-1:0] va_rdata;
    logic                      va_we;
    logic [VTX_W-1:0]          edge_rdata;
    logic                      edge_we;
    logic [STK_W-1:0]          stk_waddr, stk_raddr;
    logic [VTX_W+SLOT_W-1:0]   stk_rdata;
    logic [SLOT_W-1:0]         slot_inc;
    logic                      is_vtx_load;

    // memory port addressing
    assign is_vtx_load = i_cmd.load && (i_item.cmd == CMD_LOAD_VTX);
    assign fe_we    = is_vtx_load && (i_item.vertex <= VIN_W'(NUM_VERTICES));
    assign va_we    = is_vtx_load && (i_item.vertex < VIN_W'(NUM_VERTICES));
    assign edge_we  = i_cmd.load && (i_item.cmd == CMD_LOAD_EDGE)
                      && ({1'b0, i_item.edge_slot} < SLOT_W'(NUM_EDGES));
    assign fe_waddr = i_item.vertex;
    assign fe_raddr = i_cmd.rd_fe1 ? ({1'b0, r_node} + VIN_W'(1)) : {1'b0, r_node};
    assign va_raddr = i_cmd.rd_tgt ? i_item.target_vertex : r_node;
    assign stk_waddr = STK_W'(r_sp - SP_W'(1));
    assign stk_raddr = STK_W'(r_sp - SP_W'(2));
    assign slot_inc  = r_slot + SLOT_W'(1);

    idr_ram #(.W(SLOT_W), .D(NUM_VERTICES + 1)) u_fe_ram (
        .i_clk(i_clk), .i_we(fe_we), .i_waddr(fe_waddr), .i_wdata(i_item.first_edge),
        .i_raddr(fe_raddr), .o_rdata(fe_rdata)
    );

    idr_ram #(.W($bits(t_vattr)), .D(NUM_VERTICES)) u_vattr_ram (
        .i_clk(i_clk), .i_we(va_we), .i_waddr(i_item.vertex[VTX_W-1:0]),
        .i_wdata(i_item.attr), .i_raddr(va_raddr), .o_rdata(va_rdata)
    );

    idr_ram #(.W(VTX_W), .D(NUM_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(edge_we), .i_waddr(i_item.edge_slot),
        .i_wdata(i_item.edge_target), .i_raddr(r_slot[EDG_W-1:0]), .o_rdata(edge_rdata)
    );

    idr_ram #(.W(VTX_W + SLOT_W), .D(STACK_DEPTH)) u_stack_ram (
        .i_clk(i_clk), .i_we(i_cmd.push), .i_waddr(stk_waddr),
        .i_wdata({r_node, slot_inc}), .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_tgt) begin
            r_src <= i_item.vertex[VTX_W-1:0];
            r_dst <= i_item.target_vertex;
        end
        if (i_cmd.ld_tgt) begin
            r_t <= t_vattr'(va_rdata);
        end
        if (i_cmd.start) begin
            r_node <= r_src;
        end else if (i_cmd.push) begin
            r_node <= edge_rdata;
        end else if (i_cmd.ld_top) begin
            r_node <= stk_rdata[VTX_W+SLOT_W-1:SLOT_W];
        end
        if (i_cmd.ld_fe0) begin
            r_fe0 <= fe_rdata;
            r_n   <= t_vattr'(va_rdata);
        end
        if (i_cmd.ld_fe1) begin
            r_fe1 <= fe_rdata;
        end
        if (i_cmd.ld_fe0 && r_fresh) begin
            r_slot <= fe_rdata;
        end else if (i_cmd.adv) begin
            r_slot <= slot_inc;
        end else if (i_cmd.ld_top) begin
            r_slot <= stk_rdata[SLOT_W-1:0];
        end
        if (i_cmd.set_res) begin
            r_res_flag <= i_cmd.res_flag;
            r_res_bad  <= i_cmd.res_bad;
        end
        if (i_cmd.emit) begin
            r_out <= {r_res_bad, r_res_flag};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp        <= '0;
            r_fresh     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_sp <= SP_W'(1);
            end else if (i_cmd.push) begin
                r_sp <= r_sp + SP_W'(1);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - SP_W'(1);
            end
            if (i_cmd.start || i_cmd.push) begin
                r_fresh <= 1'b1;
            end else if (i_cmd.ld_fe0 || i_cmd.ld_top) begin
                r_fresh <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // tests on the top frame
    always_comb begin
        o_status.range_ok   = i_item.vertex < VIN_W'(NUM_VERTICES);
        o_status.first      = r_slot == r_fe0;
        o_status.hit        = ((r_n.int_lo <= r_t.int_lo) && (r_t.int_hi <= r_n.int_hi))
                              || (r_node == r_dst);
        o_status.prune      = !((r_n.rank_x <= r_t.rank_x) && (r_n.rank_y <= r_t.rank_y)
                              && (r_n.level < r_t.level));
        o_status.has_child  = (r_slot < r_fe1) && (r_slot < SLOT_W'(NUM_EDGES));
        o_status.child_oob  = {1'b0, edge_rdata} >= VIN_W'(NUM_VERTICES);
        o_status.stack_full = r_sp >= SP_W'(STACK_DEPTH);
        o_status.sp_last    = r_sp == SP_W'(1);
        o_status.out_busy   = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_result   = r_out;
endmodule

// File: design/idr_ctrl.sv
module idr_ctrl
    import idr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  logic [1:0] i_cmd_code,
    input  t_status i_status,
    output logic    o_s_tready,
    output t_cmd    o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TGT  = 4'd1;
    localparam logic [3:0] S_FE0  = 4'd2;
    localparam logic [3:0] S_FE1  = 4'd3;
    localparam logic [3:0] S_FE2  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_EDGE = 4'd6;
    localparam logic [3:0] S_POP  = 4'd7;
    localparam logic [3:0] S_TOP  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state, n_state;
    logic       acc;

    assign o_s_tready = r_state == S_IDLE;
    assign acc        = i_s_tvalid && o_s_tready;

    // walk sequencer
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load   = acc;
                o_cmd.rd_tgt = acc && (i_cmd_code == CMD_QUERY);
                if (acc && (i_cmd_code == CMD_QUERY)) begin
                    if (i_status.range_ok) begin
                        n_state = S_TGT;
                    end else begin
                        o_cmd.set_res = 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_TGT: begin
                o_cmd.ld_tgt = 1'b1;
                o_cmd.start  = 1'b1;
                n_state = S_FE0;
            end
            S_FE0: n_state = S_FE1;
            S_FE1: begin
                o_cmd.ld_fe0 = 1'b1;
                o_cmd.rd_fe1 = 1'b1;
                n_state = S_FE2;
            end
            S_FE2: begin
                o_cmd.ld_fe1 = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                priority if (i_status.first && i_status.hit) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_flag = 1'b1;
                    n_state = S_DONE;
                end else if (i_status.first && i_status.prune) begin
                    n_state = S_POP;
                end else if (i_status.has_child) begin
                    n_state = S_EDGE;
                end else begin
                    n_state = S_POP;
                end
            end
            S_EDGE: begin
                priority if (i_status.child_oob) begin
                    o_cmd.adv = 1'b1;
                    n_state = S_CHK;
                end else if (i_status.stack_full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_bad = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state = S_FE0;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                if (i_status.sp_last) begin
                    o_cmd.set_res = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                o_cmd.ld_top = 1'b1;
                n_state = S_FE0;
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: design/indexed_dag_reachability_query.sv
// Reachability queries over a DAG loaded in compressed adjacency form. Load items
// (tuser 0 vertex record, 1 edge slot) give no result and leave the block ready; a
// query (tuser 2) gives one result item. A query walks depth first with a stack
// held in memory. After the accept, state S_TGT loads the target record. Each visit
// of a vertex then passes S_FE0, S_FE1, S_FE2 and S_CHK to read its record and edge
// bounds and test it. Each child pushed adds a pass through S_EDGE. Each backtrack
// passes S_POP and S_TOP and then re-reads the parent. The result is posted from
// S_DONE once the output register is free. A source out of range goes straight to
// S_DONE. The single read port of each memory sets this pace. A new item is
// accepted while the previous result still waits on the output register.
module indexed_dag_reachability_query
    import idr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // vertex, target_vertex, first_edge, edge_slot, edge_target,
    // interval_lo, interval_hi, rank_x, rank_y, depth_level
    input  logic [111:0] i_s_tdata,
    // cmd
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // reachable_flag, bad_graph
    output logic [7:0]   o_m_tdata
);
    t_item   item;
    t_cmd    cmd;
    t_status status;
    logic [1:0] result;

    // unpack the input item
    always_comb begin
        item.cmd           = i_s_tuser;
        item.vertex        = i_s_tdata[10:0];
        item.target_vertex = i_s_tdata[20:11];
        item.first_edge    = i_s_tdata[33:21];
        item.edge_slot     = i_s_tdata[45:34];
        item.edge_target   = i_s_tdata[55:46];
        item.attr.int_lo   = i_s_tdata[65:56];
        item.attr.int_hi   = i_s_tdata[75:66];
        item.attr.rank_x   = i_s_tdata[85:76];
        item.attr.rank_y   = i_s_tdata[95:86];
        item.attr.level    = i_s_tdata[105:96];
    end

    idr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid),
        .i_cmd_code(i_s_tuser), .i_status(status), .o_s_tready(o_s_tready), .o_cmd(cmd)
    );

    idr_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(item), .i_cmd(cmd),
        .i_m_tready(i_m_tready), .o_status(status), .o_m_tvalid(o_m_tvalid),
        .o_result(result)
    );

    assign o_m_tdata = {6'd0, result};
endmodule

// File: design/idr_checker.sv
module idr_checker
    import idr_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [1:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [7:0]   o_m_tdata
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed under stall");

    // no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // overflow never reports reachable
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("reachable and bad_graph both set");

    // padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:2] == 6'd0)
        else $error("padding bits set");

    // a load item never makes a result appear
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != CMD_QUERY && !o_m_tvalid |=> !o_m_tvalid)
        else $error("result after load item");
endmodule

bind indexed_dag_reachability_query idr_checker u_idr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
    .i_s_tuser(i_s_tuser), .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
    .o_m_tdata(o_m_tdata)
);
